// ===== rtl/sensor_frame_crc_checker_assert.svh =====
// Assertion macros shared by the frame checker modules.
`ifndef SENSOR_FRAME_CRC_CHECKER_ASSERT_SVH
`define SENSOR_FRAME_CRC_CHECKER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define SFCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define SFCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SFCC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SFCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/sfcc_pkg.sv =====
// Types, constants and the CRC-16/Modbus byte update for the frame checker.
package sfcc_pkg;

   typedef logic [4:0] pos_type;

   localparam pos_type FrameLen        = 5'd17;
   localparam pos_type PosHeaderFirst  = 5'd0;
   localparam pos_type PosHeaderSecond = 5'd1;
   localparam pos_type PosCrcFirst     = 5'd2;
   localparam pos_type PosCrcLast      = 5'd14;
   localparam pos_type PosPayloadFirst = 5'd9;
   localparam pos_type PosCrcLow       = 5'd15;
   localparam pos_type PosCrcHigh      = 5'd16;

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;

   localparam logic [7:0] HeaderFirstReset  = 8'h42;
   localparam logic [7:0] HeaderSecondReset = 8'h4D;

   localparam int PayloadWidth = 48;

   typedef enum logic [0:0] {
      CSR_HEADER_FIRST  = 1'b0,
      CSR_HEADER_SECOND = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_GOOD       = 2'd0,
      STATUS_HEADER_BAD = 2'd1,
      STATUS_CRC_BAD    = 2'd2
   } status_type;

   typedef struct packed {
      status_type                status;
      logic [PayloadWidth-1:0]   payload;
   } rsp_data_type;

   typedef struct packed {
      logic         valid;
      rsp_data_type data;
   } frame_result_type;

   // Reflected CRC-16 update over one byte, eight shift steps.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/sfcc_req_if.sv =====
// Byte input channel: valid/ready handshake with one received byte and a start flag.
interface sfcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== rtl/sfcc_rsp_if.sv =====
// Result channel: valid/ready handshake with frame status and payload.
interface sfcc_rsp_if import sfcc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic [PayloadWidth-1:0] payload;

   modport source (output valid, output status, output payload, input ready);
   modport sink   (input valid, input status, input payload, output ready);
endinterface

// ===== rtl/sfcc_frame_track.sv =====
// Frame position tracking, header check, CRC accumulation and result forming.
module sfcc_frame_track import sfcc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [7:0]       csr_wdata,
   input  logic             accept,
   input  logic [7:0]       rx_byte,
   input  logic             frame_start,
   output frame_result_type result
);

   logic [7:0]              header_first_ff, header_first_in;
   logic [7:0]              header_second_ff, header_second_in;
   pos_type                 pos_ff, pos_in;
   logic [15:0]             crc_ff, crc_in;
   logic [PayloadWidth-1:0] payload_ff, payload_in;
   logic                    header_good_ff, header_good_in;
   logic [7:0]              crc_low_ff, crc_low_in;

   pos_type                 pos_eff;
   logic [15:0]             crc_eff;
   logic [PayloadWidth-1:0] payload_eff;
   logic                    header_good_eff;
   logic                    active;

   always_comb begin
      header_first_in  = header_first_ff;
      header_second_in = header_second_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_HEADER_FIRST:  header_first_in  = csr_wdata;
            CSR_HEADER_SECOND: header_second_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // A start flag restarts the frame with this byte, whatever came before.
   always_comb begin
      pos_eff         = frame_start ? PosHeaderFirst : pos_ff;
      crc_eff         = frame_start ? CrcInit : crc_ff;
      payload_eff     = frame_start ? '0 : payload_ff;
      header_good_eff = frame_start ? 1'b0 : header_good_ff;
      active          = pos_eff < FrameLen;
   end

   always_comb begin
      pos_in         = pos_ff;
      crc_in         = crc_ff;
      payload_in     = payload_ff;
      header_good_in = header_good_ff;
      crc_low_in     = frame_start ? 8'h00 : crc_low_ff;
      result         = '0;
      if (accept) begin
         crc_in         = crc_eff;
         payload_in     = payload_eff;
         header_good_in = header_good_eff;
         if (active) begin
            if (pos_eff == PosHeaderFirst) begin
               header_good_in = (rx_byte == header_first_ff);
            end else if (pos_eff == PosHeaderSecond) begin
               header_good_in = header_good_eff && (rx_byte == header_second_ff);
            end
            if (pos_eff >= PosCrcFirst && pos_eff <= PosCrcLast) begin
               crc_in = crc16_byte(crc_eff, rx_byte);
            end
            if (pos_eff >= PosPayloadFirst && pos_eff <= PosCrcLast) begin
               payload_in = {payload_eff[PayloadWidth-9:0], rx_byte};
            end
            if (pos_eff == PosCrcLow) begin
               crc_low_in = rx_byte;
            end
            if (pos_eff == PosCrcHigh) begin
               pos_in       = FrameLen;
               result.valid = 1'b1;
               if (!header_good_eff) begin
                  result.data.status = STATUS_HEADER_BAD;
               end else if ({rx_byte, crc_low_ff} == crc_eff) begin
                  result.data.status  = STATUS_GOOD;
                  result.data.payload = payload_eff;
               end else begin
                  result.data.status = STATUS_CRC_BAD;
               end
            end else begin
               pos_in = pos_eff + 5'd1;
            end
         end else begin
            pos_in = pos_eff;
         end
      end else begin
         crc_low_in = crc_low_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HeaderFirstReset;
         header_second_ff <= HeaderSecondReset;
         pos_ff           <= FrameLen;
         crc_ff           <= CrcInit;
         header_good_ff   <= 1'b0;
      end else begin
         header_first_ff  <= header_first_in;
         header_second_ff <= header_second_in;
         pos_ff           <= pos_in;
         crc_ff           <= crc_in;
         header_good_ff   <= header_good_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      crc_low_ff <= crc_low_in;
   end

`include "sensor_frame_crc_checker_assert.svh"

   `SFCC_ASSERT_NOW(a_pos_range, clock, reset, 1'b1, pos_ff <= FrameLen, "frame position out of range")
   `SFCC_ASSERT_NOW(a_result_at_end, clock, reset, result.valid, pos_ff == PosCrcHigh && !frame_start, "result away from last byte")
   `SFCC_ASSERT_NEXT(a_idle_after_result, clock, reset, result.valid, pos_ff == FrameLen, "not idle after result")

endmodule

// ===== rtl/sfcc_out_stage.sv =====
// Result register with a one-beat skid stage so input ready does not wait on the receiver.
module sfcc_out_stage import sfcc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  rsp_data_type in_data,
   output logic         in_ready,
   output logic         out_valid,
   output rsp_data_type out_data,
   input  logic         out_ready
);

   logic         main_valid_ff, main_valid_in;
   rsp_data_type main_data_ff, main_data_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_data_type skid_data_ff, skid_data_in;
   logic         pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign pop       = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // Advance the held beat once the receiver takes the current one.
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
            main_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

`include "sensor_frame_crc_checker_assert.svh"

   `SFCC_ASSERT_NOW(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff, "skid full with empty result register")
   `SFCC_ASSERT_NOW(a_no_push_when_full, clock, reset, in_valid, !skid_valid_ff, "result pushed into full stage")
   `SFCC_ASSERT_NEXT(a_hold_stalled, clock, reset, main_valid_ff && !out_ready, main_valid_ff && $stable(main_data_ff), "stalled result dropped or changed")

endmodule

// ===== rtl/sensor_frame_crc_checker.sv =====
// Top level of the sensor reply frame checker.
// Usage:
//   req carries one reply byte per beat (rx_byte) with frame_start marking byte 0.
//   Frames are 17 bytes: two header bytes, CRC-16/Modbus over bytes 2..14,
//   payload in bytes 9..14, received CRC low then high in bytes 15 and 16.
//   rsp carries one beat per complete frame: status (0 good, 1 header mismatch,
//   2 CRC mismatch) and the 48-bit payload, zero unless the frame is good.
//   Bytes with no start flag outside a frame are dropped without a result.
//   A start flag mid-frame abandons that frame with no result.
//   Throughput: one byte per cycle while req.ready is high; the CRC byte update is one XOR network.
//   The result of byte 16 is registered in the output stage before it appears on rsp.
//   A stalled rsp holds its beat; one more result fits in the skid stage, and
//   req.ready drops only while that skid stage is full.
//   csr_we/csr_index/csr_wdata set the expected header bytes (index 0, 1);
//   write them only while no frame is in flight.
//   Reset (synchronous, active high) empties the output stage, returns to idle
//   awaiting a start flag and restores headers 0x42 and 0x4D.
module sensor_frame_crc_checker import sfcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sfcc_req_if.sink    req,
   sfcc_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   frame_result_type result;
   rsp_data_type     out_data;
   logic             accept;

   assign accept = req.valid && req.ready;

   sfcc_frame_track u_frame_track (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .rx_byte     (req.rx_byte),
      .frame_start (req.frame_start),
      .result      (result)
   );

   sfcc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (result.valid),
      .in_data   (result.data),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_data  (out_data),
      .out_ready (rsp.ready)
   );

   assign rsp.status  = out_data.status;
   assign rsp.payload = out_data.payload;

endmodule

// ===== bench/sfcc_frame_checker.sv =====
// Frame checker monitor: predicts each result beat from the byte stream and compares it.
module sfcc_frame_checker import sfcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sfcc_req_if         req,
   sfcc_rsp_if         rsp,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int unsigned mismatch_count,
   output int unsigned results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]              header_first_q;
   logic [7:0]              header_second_q;
   pos_type                 frame_pos;
   logic [15:0]             crc_acc;
   logic [PayloadWidth-1:0] payload_acc;
   logic                    header_ok;
   logic [7:0]              crc_low_q;
   rsp_data_type            awaited_results[$];
   int unsigned             fault_total = 0;

   // Bit-serial form of the reflected CRC-16 update, LSB of the byte first.
   function automatic logic [15:0] crc_fold_byte(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ b[i];
         r  = r >> 1;
         if (fb) r = r ^ CrcPoly;
      end
      return r;
   endfunction

   task automatic track_frame_byte(input logic [7:0] b, input logic start);
      rsp_data_type res;
      if (start) begin
         frame_pos   = PosHeaderFirst;
         crc_acc     = CrcInit;
         payload_acc = '0;
         header_ok   = 1'b0;
         crc_low_q   = '0;
      end
      // drop bytes that arrive outside a frame
      if (frame_pos >= FrameLen) return;
      if (frame_pos == PosHeaderFirst) header_ok = (b == header_first_q);
      else if (frame_pos == PosHeaderSecond) header_ok = header_ok && (b == header_second_q);
      if (frame_pos >= PosCrcFirst && frame_pos <= PosCrcLast) crc_acc = crc_fold_byte(crc_acc, b);
      if (frame_pos >= PosPayloadFirst && frame_pos <= PosCrcLast) begin
         payload_acc = {payload_acc[PayloadWidth-9:0], b};
      end
      if (frame_pos == PosCrcLow) crc_low_q = b;
      if (frame_pos == PosCrcHigh) begin
         res.payload = '0;
         if (!header_ok) begin
            res.status = STATUS_HEADER_BAD;
         end else if ({b, crc_low_q} == crc_acc) begin
            res.status  = STATUS_GOOD;
            res.payload = payload_acc;
         end else begin
            res.status = STATUS_CRC_BAD;
         end
         awaited_results.push_back(res);
         frame_pos = FrameLen;
      end else begin
         frame_pos = frame_pos + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      rsp_data_type want;
      if (reset) begin
         header_first_q  = HeaderFirstReset;
         header_second_q = HeaderSecondReset;
         frame_pos       = FrameLen;
         crc_acc         = CrcInit;
         payload_acc     = '0;
         header_ok       = 1'b0;
         crc_low_q       = '0;
         awaited_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HEADER_FIRST:  header_first_q  = csr_wdata;
               CSR_HEADER_SECOND: header_second_q = csr_wdata;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result beat: status %0d payload %h", rsp.status, rsp.payload);
               fault_total++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  fault_total++;
               end
               if (rsp.payload !== want.payload) begin
                  $error("payload: expected %h, got %h", want.payload, rsp.payload);
                  fault_total++;
               end
            end
         end
         if (req.valid && req.ready) track_frame_byte(req.rx_byte, req.frame_start);
      end
      results_pending <= awaited_results.size();
      mismatch_count  <= fault_total;
   end

endmodule

// ===== bench/sensor_frame_crc_checker_tb.sv =====
// Testbench top: drives reply bytes and header settings, and gives the verdict.
module sensor_frame_crc_checker_tb import sfcc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned StallLimit  = 5000;
   localparam int unsigned PhaseBeats  = 380;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [7:0]  csr_wdata;
   int unsigned mismatch_count;
   int unsigned results_pending;
   int unsigned beats_sent = 0;
   int unsigned stall_cycles = 0;
   bit          steady = 1'b0;
   logic [7:0]  hdr_first = HeaderFirstReset;
   logic [7:0]  hdr_second = HeaderSecondReset;

   sfcc_req_if req_ch ();
   sfcc_rsp_if rsp_ch ();

   sensor_frame_crc_checker dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sfcc_frame_checker frame_check (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= StallLimit) begin
            $display("FAIL sensor_frame_crc_checker");
            $finish;
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Result side back-pressure.
   initial begin
      int unsigned hold;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         hold = pick_gap();
         if (hold != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic start, input bit counted);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.rx_byte     <= b;
      req_ch.frame_start <= start;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (counted) beats_sent++;
   endtask

   task automatic send_frame(input logic [7:0] first, input logic [7:0] second,
                             input bit spoil_crc, input bit extreme_body);
      logic [7:0]  fb [FrameLen];
      logic [15:0] crc;
      int unsigned spot;
      fb[PosHeaderFirst]  = first;
      fb[PosHeaderSecond] = second;
      crc = CrcInit;
      for (int i = PosCrcFirst; i <= PosCrcLast; i++) begin
         fb[i] = extreme_body ? ((i % 2 != 0) ? 8'h00 : 8'hFF) : 8'($urandom);
         crc   = crc16_byte(crc, fb[i]);
      end
      fb[PosCrcLow]  = crc[7:0];
      fb[PosCrcHigh] = crc[15:8];
      // a single flipped bit anywhere past the header always breaks the CRC
      if (spoil_crc) begin
         spot     = $urandom_range(PosCrcFirst, PosCrcHigh);
         fb[spot] = fb[spot] ^ (8'h01 << $urandom_range(0, 7));
      end
      for (int i = 0; i < FrameLen; i++) send_beat(fb[i], i == 0, 1'b1);
   endtask

   // Abandon a frame part-way; the next start flag restarts it.
   task automatic send_partial();
      int unsigned n;
      logic [7:0]  b;
      n = $urandom_range(1, PosCrcHigh);
      for (int i = 0; i < n; i++) begin
         b = (i == 0 && $urandom_range(0, 1) != 0) ? hdr_first : 8'($urandom);
         send_beat(b, i == 0, 1'b1);
      end
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_headers(input logic [7:0] first, input logic [7:0] second);
      csr_we    <= 1'b1;
      csr_index <= CSR_HEADER_FIRST;
      csr_wdata <= first;
      @(posedge clock);
      csr_index <= CSR_HEADER_SECOND;
      csr_wdata <= second;
      @(posedge clock);
      csr_we     <= 1'b0;
      hdr_first  = first;
      hdr_second = second;
   endtask

   task automatic run_random(input int unsigned quota);
      int unsigned stop_at;
      int unsigned pick;
      bit          at_rest;
      logic [7:0]  bad_first;
      logic [7:0]  bad_second;
      stop_at = beats_sent + quota;
      at_rest = 1'b1;
      while (beats_sent < stop_at) begin
         if ($urandom_range(0, 7) == 0) steady = !steady;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_frame(hdr_first, hdr_second, 1'b0, 1'b0);
            at_rest = 1'b1;
         end else if (pick < 67) begin
            send_frame(hdr_first, hdr_second, 1'b1, 1'b0);
            at_rest = 1'b1;
         end else if (pick < 77) begin
            bad_first  = hdr_first;
            bad_second = hdr_second;
            case ($urandom_range(0, 2))
               0: bad_first = bad_first ^ 8'($urandom_range(1, 255));
               1: bad_second = bad_second ^ 8'($urandom_range(1, 255));
               default: begin
                  bad_first  = bad_first ^ 8'($urandom_range(1, 255));
                  bad_second = bad_second ^ 8'($urandom_range(1, 255));
               end
            endcase
            send_frame(bad_first, bad_second, $urandom_range(0, 1) != 0, 1'b0);
            at_rest = 1'b1;
         end else if (pick < 87) begin
            send_partial();
            at_rest = 1'b0;
         end else if (at_rest) begin
            // stray bytes between frames, dropped by the block
            repeat ($urandom_range(1, 3)) send_beat(8'($urandom), 1'b0, 1'b0);
         end
      end
      // close on a whole frame so the block is idle before any header write
      steady = 1'b0;
      send_frame(hdr_first, hdr_second, 1'b0, 1'b0);
      settle();
   endtask

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_HEADER_FIRST;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.rx_byte     <= '0;
      req_ch.frame_start <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'hFF, 1'b0, 1'b0);
      send_beat(HeaderFirstReset, 1'b1, 1'b1);
      send_frame(hdr_first, hdr_second, 1'b0, 1'b1);
      run_random(PhaseBeats);

      write_headers(8'h00, 8'hFF);
      run_random(PhaseBeats);
      write_headers(8'hFF, 8'h00);
      run_random(PhaseBeats);
      write_headers(8'($urandom), 8'($urandom));
      run_random(PhaseBeats);
      write_headers(HeaderFirstReset, HeaderSecondReset);
      run_random(PhaseBeats);

      if (mismatch_count == 0) begin
         $display("PASS sensor_frame_crc_checker");
      end else begin
         $display("FAIL sensor_frame_crc_checker");
      end
      $finish;
   end

endmodule

// ===== sensor_frame_crc_checker.f =====
+incdir+rtl
rtl/sfcc_pkg.sv
rtl/sfcc_req_if.sv
rtl/sfcc_rsp_if.sv
rtl/sfcc_frame_track.sv
rtl/sfcc_out_stage.sv
rtl/sensor_frame_crc_checker.sv
bench/sfcc_frame_checker.sv
bench/sensor_frame_crc_checker_tb.sv
